>>> rtl/fifo_with_threshold_purge_top_macros.svh
// Assertion macros shared by the threshold-purge FIFO.
`ifndef FIFO_WITH_THRESHOLD_PURGE_TOP_MACROS_SVH
`define FIFO_WITH_THRESHOLD_PURGE_TOP_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define FWTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define FWTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fwtp_pkg.sv
// Package with the types and constants of the threshold-purge FIFO.
package fwtp_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // Head value reported while the queue is empty.
    localparam logic [DATA_W-1:0] EMPTY_HEAD = {DATA_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PURGE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PURGE,
        S_HEAD,
        S_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic purge_step;
        logic head_rd;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_purge;
        logic purge_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/fwtp_in_if.sv
// Request channel: command and value with a valid/ready handshake.
interface fwtp_in_if;
    logic                          valid;
    logic                          ready;
    logic [fwtp_pkg::CMD_W-1:0]    command;
    logic signed [fwtp_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

>>> rtl/fwtp_out_if.sv
// Result channel: head value, empty flag, count and status with valid/ready.
interface fwtp_out_if #(
    parameter int CNT_W = 5
);
    logic                               valid;
    logic                               ready;
    logic signed [fwtp_pkg::DATA_W-1:0] head_value;
    logic                               is_empty;
    logic [CNT_W-1:0]                   entry_count;
    logic [fwtp_pkg::STAT_W-1:0]        status;

    modport source (
        output valid, output head_value, output is_empty,
        output entry_count, output status, input ready
    );
    modport sink (
        input valid, input head_value, input is_empty,
        input entry_count, input status, output ready
    );
endinterface

>>> rtl/fifo_with_threshold_purge_top.sv
// Top level of the bounded FIFO with push, pop and threshold purge.
//
// The block takes one request at a time. A push, a pop or an unused command
// goes through execute, read of the head entry, and load of the result
// register before the next acceptance. A purge walks the stored entries
// through the single read port of the entry memory, one entry per cycle,
// before the head read and load. The result sits in an output register, so the
// next request is accepted while the previous result waits to be taken. A
// result that is still waiting when the next one is ready holds the block in
// its load step. The entry memory is not cleared after reset; only live
// entries reach the result register.
module fifo_with_threshold_purge_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fwtp_in_if.sink     i_req,
    fwtp_out_if.source  o_rsp
);
    import fwtp_pkg::*;

    `include "fifo_with_threshold_purge_top_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // Sequencer.
    fwtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // Storage and arithmetic.
    fwtp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_req.command),
        .i_value       (i_req.value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_head_value  (o_rsp.head_value),
        .o_is_empty    (o_rsp.is_empty),
        .o_entry_count (o_rsp.entry_count),
        .o_status      (o_rsp.status)
    );

    // A new result never overwrites one that has not been taken.
    `FWTP_ASSERT_SAME(a_load_free, w_cmd.load_out, w_stat.out_free, "result overwritten")
    // After a request is accepted, ready is low in the next cycle.
    `FWTP_ASSERT_NEXT(a_busy, i_req.valid && i_req.ready, !i_req.ready, "ready after accept")
    // An empty queue reports all ones as head value.
    `FWTP_ASSERT_SAME(a_empty_head, o_rsp.valid && o_rsp.is_empty, o_rsp.head_value == -1, "bad empty head")
    // A refused push is only reported with a full queue.
    `FWTP_ASSERT_SAME(a_full_cnt, o_rsp.valid && (o_rsp.status == ST_FULL), o_rsp.entry_count == CNT_W'(QUEUE_DEPTH), "full status")

endmodule

>>> rtl/fwtp_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module fwtp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output fwtp_pkg::t_ctrl_cmd o_cmd,
    input  fwtp_pkg::t_dp_stat  i_stat
);
    import fwtp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.is_purge ? S_PURGE : S_HEAD;
            end
            S_PURGE: begin
                o_cmd.purge_step = 1'b1;
                if (i_stat.purge_done) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                // Hold the head read data until the result register is free.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/fwtp_dp.sv
// Datapath: entry memory, queue pointers, purge scan and result register.
module fwtp_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fwtp_pkg::t_ctrl_cmd                i_cmd,
    output fwtp_pkg::t_dp_stat                 o_stat,
    input  logic [fwtp_pkg::CMD_W-1:0]         i_command,
    input  logic signed [fwtp_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [fwtp_pkg::DATA_W-1:0] o_head_value,
    output logic                               o_is_empty,
    output logic [CNT_W-1:0]                   o_entry_count,
    output logic [fwtp_pkg::STAT_W-1:0]        o_status
);
    import fwtp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int SW = CNT_W + 1;
    localparam logic [SW-1:0]    DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Circular index add; the base stays below the depth and the offset at most equals it.
    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [DATA_W-1:0]        mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    logic [CMD_W-1:0]         r_cmd;
    logic signed [DATA_W-1:0] r_value;
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_tail;
    logic [CNT_W-1:0]         r_count;
    t_status                  r_status;
    logic [CNT_W-1:0]         r_scan;
    logic [CNT_W-1:0]         r_kept;
    logic                     r_pipe_vld;

    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_head;
    logic                     r_out_empty;
    logic [CNT_W-1:0]         r_out_count;
    t_status                  r_out_status;

    logic              w_full;
    logic              w_empty;
    logic              w_scan_more;
    logic              w_keep;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;

    assign w_full      = (r_count == DEPTH_C);
    assign w_empty     = (r_count == '0);
    assign w_scan_more = (r_scan < r_count);
    assign w_keep      = !(r_rd_data > r_value);

    // Status toward the controller.
    assign o_stat.is_purge   = (r_cmd == CMD_PURGE);
    assign o_stat.purge_done = !w_scan_more && !r_pipe_vld;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    // Memory port selection: one read and one write per cycle.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        w_wr_data = r_value;
        if (i_cmd.head_rd) begin
            w_rd_en = 1'b1;
        end else if (i_cmd.purge_step && w_scan_more) begin
            w_rd_en   = 1'b1;
            w_rd_addr = f_wrap_add(r_head, r_scan);
        end
        if (i_cmd.exec && (r_cmd == CMD_PUSH) && !w_full) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.purge_step && r_pipe_vld && w_keep) begin
            w_wr_en   = 1'b1;
            w_wr_addr = f_wrap_add(r_head, r_kept);
            w_wr_data = r_rd_data;
        end
    end

    // Entry memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
    end

    // Queue pointers, count and purge scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_status   <= ST_OK;
            r_scan     <= '0;
            r_kept     <= '0;
            r_pipe_vld <= 1'b0;
        end else if (i_cmd.exec) begin
            r_status   <= ST_OK;
            r_scan     <= '0;
            r_kept     <= '0;
            r_pipe_vld <= 1'b0;
            case (r_cmd)
                CMD_PUSH: begin
                    if (w_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_tail  <= f_wrap_add(r_tail, CNT_W'(1));
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (w_empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_head  <= f_wrap_add(r_head, CNT_W'(1));
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.purge_step) begin
            // Reads run one entry ahead of the compare and compaction write.
            r_pipe_vld <= w_scan_more;
            if (w_scan_more) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (r_pipe_vld && w_keep) begin
                r_kept <= r_kept + CNT_W'(1);
            end
            if (!w_scan_more && !r_pipe_vld) begin
                r_count <= r_kept;
                r_tail  <= f_wrap_add(r_head, r_kept);
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_head   <= w_empty ? EMPTY_HEAD : r_rd_data;
            r_out_empty  <= w_empty;
            r_out_count  <= r_count;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_head_value  = r_out_head;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

>>> test/fifo_with_threshold_purge_top_test.sv
// Self-checking testbench for the threshold-purge FIFO with random handshake pressure.
`timescale 1ns / 1ps

module fifo_with_threshold_purge_top_test;
    import fwtp_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = 5;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 300;

    // The package names only three command codes; the fourth is a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;

    typedef struct {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } t_fifo_request;

    typedef struct {
        logic [DATA_W-1:0] head_value;
        logic              is_empty;
        logic [CNT_W-1:0]  entry_count;
        t_status           status;
    } t_fifo_report;

    logic i_clk;
    logic i_rst_n;

    fwtp_in_if                    req_if ();
    fwtp_out_if #(.CNT_W(CNT_W))  rsp_if ();

    fifo_with_threshold_purge_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Requests waiting to be offered, and reports predicted for accepted requests.
    t_fifo_request command_backlog[$];
    t_fifo_report  predicted_reports[$];

    // Shadow of the queue contents, head first.
    logic signed [DATA_W-1:0] shadow_entries[$];

    int total_requests;
    int requests_accepted;
    int reports_checked;
    int error_count;
    int cycle_count;

    int push_total, push_refused, pop_total, pop_on_empty;
    int purge_total, purge_removed, unused_total;

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Apply one accepted request to the shadow queue and return the report it yields.
    function automatic t_fifo_report apply_fifo_command(input logic [CMD_W-1:0] cmd,
                                                        input logic signed [DATA_W-1:0] val);
        t_fifo_report             rep;
        logic signed [DATA_W-1:0] survivors[$];
        rep.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                push_total++;
                if (shadow_entries.size() >= QUEUE_DEPTH) begin
                    rep.status = ST_FULL;
                    push_refused++;
                end else begin
                    shadow_entries.push_back(val);
                end
            end
            CMD_POP: begin
                pop_total++;
                if (shadow_entries.size() == 0) begin
                    rep.status = ST_EMPTY;
                    pop_on_empty++;
                end else begin
                    void'(shadow_entries.pop_front());
                end
            end
            CMD_PURGE: begin
                // Keep entries not above the threshold, in their original order.
                purge_total++;
                foreach (shadow_entries[k]) begin
                    if (!(shadow_entries[k] > val)) begin
                        survivors.push_back(shadow_entries[k]);
                    end
                end
                purge_removed += shadow_entries.size() - survivors.size();
                shadow_entries = survivors;
            end
            default: begin
                unused_total++;
            end
        endcase
        rep.is_empty    = (shadow_entries.size() == 0);
        rep.head_value  = rep.is_empty ? EMPTY_HEAD : shadow_entries[0];
        rep.entry_count = CNT_W'(shadow_entries.size());
        return rep;
    endfunction

    function automatic void queue_request(input logic [CMD_W-1:0] cmd,
                                          input logic signed [DATA_W-1:0] val);
        t_fifo_request req;
        req.command = cmd;
        req.value   = val;
        command_backlog.push_back(req);
    endfunction

    // Mix of extremes, full-range values and small values that make purges selective.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) begin
            case ($urandom_range(3, 0))
                0: return MAX_VALUE;
                1: return MIN_VALUE;
                2: return '0;
                default: return -1;
            endcase
        end else if (r <= 4) begin
            return $urandom;
        end
        return $signed($urandom_range(40, 0)) - 20;
    endfunction

    // Driver: offers requests from the backlog and predicts each accepted one.
    always @(posedge i_clk) begin
        t_fifo_request next_req;
        int            send_idle_pct;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predicted_reports.push_back(apply_fifo_command(req_if.command, req_if.value));
                requests_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                send_idle_pct = (requests_accepted < 350) ? 16 :
                                (requests_accepted < 700) ? 78 : 0;
                if (command_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    next_req = command_backlog.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.command <= next_req.command;
                    req_if.value   <= next_req.value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction and drives ready.
    always @(posedge i_clk) begin
        t_fifo_report want;
        int           recv_idle_pct;
        int           hold_left;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (predicted_reports.size() == 0) begin
                    $error("result with no request pending: head_value %0d, count %0d",
                           $signed(rsp_if.head_value), rsp_if.entry_count);
                    error_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (rsp_if.head_value !== want.head_value) begin
                        $error("head_value mismatch: expected %0d, actual %0d",
                               $signed(want.head_value), $signed(rsp_if.head_value));
                        error_count++;
                    end
                    if (rsp_if.is_empty !== want.is_empty) begin
                        $error("is_empty mismatch: expected %0d, actual %0d",
                               want.is_empty, rsp_if.is_empty);
                        error_count++;
                    end
                    if (rsp_if.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, rsp_if.entry_count);
                        error_count++;
                    end
                    if (rsp_if.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_if.status);
                        error_count++;
                    end
                end
                reports_checked++;
                // Long back-pressure windows so the block stalls its request side.
                if (reports_checked == 150 || reports_checked == 900) begin
                    hold_left = LONG_HOLD;
                end
            end
            recv_idle_pct = (reports_checked < 350) ? 78 :
                            (reports_checked < 700) ? 16 : 0;
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL fifo_with_threshold_purge_top");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        logic signed [DATA_W-1:0] recent_pushes[$];
        logic signed [DATA_W-1:0] v;
        int seg, n, r;

        req_if.valid   = 1'b0;
        req_if.command = CMD_PUSH;
        req_if.value   = '0;
        rsp_if.ready   = 1'b0;
        i_rst_n        = 1'b0;

        // Directed part: empty-queue corners, extreme values, purges of none, some, all.
        queue_request(CMD_POP, 0);
        queue_request(CMD_PURGE, 0);
        queue_request(CMD_UNUSED, -1);
        queue_request(CMD_PUSH, MAX_VALUE);
        queue_request(CMD_PUSH, MIN_VALUE);
        queue_request(CMD_PUSH, -1);
        queue_request(CMD_PUSH, 0);
        queue_request(CMD_PURGE, MAX_VALUE);
        queue_request(CMD_PURGE, 0);
        queue_request(CMD_UNUSED, MAX_VALUE);
        queue_request(CMD_POP, MIN_VALUE);
        queue_request(CMD_PURGE, MIN_VALUE);
        queue_request(CMD_PUSH, 5);
        queue_request(CMD_PUSH, 6);
        queue_request(CMD_POP, 0);
        queue_request(CMD_PURGE, 4);
        queue_request(CMD_POP, 0);
        queue_request(CMD_PUSH, 32'sh5555_5555);
        queue_request(CMD_PUSH, 32'shAAAA_AAAA);
        queue_request(CMD_PURGE, -1);
        queue_request(CMD_POP, 0);

        // Random part: fill and drain bursts, mixed traffic and purge patterns.
        // The first segment is always a burst of pushes.
        seg = 0;
        while (command_backlog.size() < 21 + RANDOM_ITEMS) begin
            if (seg <= 1) begin
                n = $urandom_range(20, 12);
                repeat (n) begin
                    v = pick_value();
                    recent_pushes.push_back(v);
                    queue_request(CMD_PUSH, v);
                end
            end else if (seg == 2) begin
                n = $urandom_range(20, 10);
                repeat (n) queue_request(CMD_POP, pick_value());
            end else if (seg <= 7) begin
                n = $urandom_range(24, 8);
                repeat (n) begin
                    r = $urandom_range(99, 0);
                    if (r < 45) begin
                        v = pick_value();
                        recent_pushes.push_back(v);
                        queue_request(CMD_PUSH, v);
                    end else if (r < 70) begin
                        queue_request(CMD_POP, pick_value());
                    end else if (r < 93) begin
                        if (recent_pushes.size() != 0 && $urandom_range(1, 0) == 1) begin
                            v = recent_pushes[$urandom_range(recent_pushes.size() - 1, 0)];
                        end else begin
                            v = pick_value();
                        end
                        queue_request(CMD_PURGE, v);
                    end else begin
                        queue_request(CMD_UNUSED, $urandom);
                    end
                end
            end else begin
                // Small values then a nearby threshold: removes none, some or all.
                n = $urandom_range(8, 3);
                repeat (n) begin
                    v = $signed($urandom_range(40, 0)) - 20;
                    recent_pushes.push_back(v);
                    queue_request(CMD_PUSH, v);
                end
                queue_request(CMD_PURGE, $signed($urandom_range(50, 0)) - 25);
            end
            while (recent_pushes.size() > QUEUE_DEPTH) void'(recent_pushes.pop_front());
            seg = $urandom_range(9, 0);
        end
        total_requests = command_backlog.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (requests_accepted == total_requests);
        wait (predicted_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d pushes (%0d refused full), %0d pops (%0d on empty),",
                 total_requests, push_total, push_refused, pop_total, pop_on_empty);
        $display("%0d purges dropping %0d entries, %0d unused codes; %0d results, %0d errors.",
                 purge_total, purge_removed, unused_total, reports_checked, error_count);
        if (error_count == 0) begin
            $display("PASS fifo_with_threshold_purge_top");
        end else begin
            $display("FAIL fifo_with_threshold_purge_top");
        end
        $finish;
    end

endmodule
